/* design/swac_pkg.sv */
// shared types and constants for the sleep/wake alarm controller
`timescale 1ns / 1ps
`default_nettype none

package swac_pkg;

    typedef enum logic [1:0] {
        MODE_AWAKE  = 2'd0,
        MODE_ASLEEP = 2'd1,
        MODE_WAKE   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        REG_SLEEP_HOURS        = 3'd0,
        REG_WAKE_LIMIT_SECONDS = 3'd1,
        REG_STILL_NEEDED       = 3'd2,
        REG_LOW_PULSE_NEEDED   = 3'd3,
        REG_SLEEP_PULSE_MAX    = 3'd4,
        REG_VALID_PULSE_MIN    = 3'd5,
        REG_VALID_PULSE_MAX    = 3'd6
    } t_reg_idx;

    localparam logic OP_EVALUATE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    localparam int REPORT_EVERY_DEF = 2;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam int HOURS_W = 5;
    localparam int SECS_W  = 17;
    localparam int BYTE_W  = 8;

    localparam logic [11:0]      SECONDS_PER_HOUR = 12'd3600;
    localparam logic [BYTE_W-1:0] PULSE_FLOOR     = 8'd30;
    localparam logic [BYTE_W-1:0] REPORT_MAX      = 8'd200;
    localparam logic [BYTE_W-1:0] COUNT_MAX       = 8'd255;

    localparam logic [HOURS_W-1:0] SLEEP_HOURS_RST      = 5'd8;
    localparam logic [SECS_W-1:0]  WAKE_LIMIT_RST       = 17'd0;
    localparam logic [BYTE_W-1:0]  STILL_NEEDED_RST     = 8'd10;
    localparam logic [BYTE_W-1:0]  LOW_PULSE_NEEDED_RST = 8'd10;
    localparam logic [BYTE_W-1:0]  SLEEP_PULSE_MAX_RST  = 8'd100;
    localparam logic [BYTE_W-1:0]  VALID_PULSE_MIN_RST  = 8'd25;
    localparam logic [BYTE_W-1:0]  VALID_PULSE_MAX_RST  = 8'd220;

endpackage

`default_nettype wire

/* design/sleep_wake_alarm_controller_core.sv */
// Sleep/wake alarm controller: takes one request per cycle and returns one result per
// request in the next cycle through an output register. Each request (evaluate or
// one-second tick) is processed in a single pass of logic between the state registers
// and the result register, so the block sustains one request per clock; it only stalls
// when the result register is full and not being taken. Configuration registers sit on
// an APB port at byte addresses 4*i and should be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module sleep_wake_alarm_controller_core #(
    parameter int REPORT_EVERY = swac_pkg::REPORT_EVERY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [swac_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [swac_pkg::PDATA_W-1:0]  pwdata,
    output logic      [swac_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,

    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_operation,
    input  wire logic                          i_motion_still,
    input  wire logic [7:0]                    i_heart_rate,
    input  wire logic                          i_button_pressed,
    input  wire logic                          i_fall_flagged,
    input  wire logic                          i_link_ready,

    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [1:0]                    o_mode,
    output logic                               o_wake_actuators_on,
    output logic                               o_actuators_stop,
    output logic                               o_fall_alert,
    output logic                               o_report_valid,
    output logic      [7:0]                    o_report_pulse_avg
);

    localparam int SUM_W       = $clog2(REPORT_EVERY * 255 + 1);
    localparam int CNT_W       = (REPORT_EVERY > 1) ? $clog2(REPORT_EVERY) : 1;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + REPORT_EVERY - 1) / REPORT_EVERY);
    localparam logic [CNT_W-1:0] LAST_READING = CNT_W'(REPORT_EVERY - 1);

    // configuration registers
    logic [swac_pkg::HOURS_W-1:0] r_sleep_hours;
    logic [swac_pkg::SECS_W-1:0]  r_wake_limit;
    logic [7:0]                   r_still_needed;
    logic [7:0]                   r_low_needed;
    logic [7:0]                   r_sleep_pulse_max;
    logic [7:0]                   r_valid_min;
    logic [7:0]                   r_valid_max;

    // run state
    swac_pkg::t_mode              r_mode, n_mode;
    logic [7:0]                   r_still_secs, n_still_secs;
    logic [7:0]                   r_low_secs, n_low_secs;
    logic [swac_pkg::SECS_W-1:0]  r_countdown, n_countdown;
    logic                         r_loaded, n_loaded;
    logic [SUM_W-1:0]             r_pulse_sum, n_pulse_sum;
    logic [CNT_W-1:0]             r_readings, n_readings;

    // result register
    logic                         r_out_valid;
    swac_pkg::t_mode              r_res_mode;
    logic                         r_res_wake_on, n_res_wake_on;
    logic                         r_res_stop, n_res_stop;
    logic                         r_res_alert, n_res_alert;
    logic                         r_res_rvalid, n_res_rvalid;
    logic [7:0]                   r_res_avg, n_res_avg;

    logic                         w_accept;
    logic                         w_cfg_wr;
    logic [2:0]                   w_cfg_idx;
    logic [16:0]                  w_full_time;
    logic [swac_pkg::SECS_W-1:0]  w_load_time;
    logic [SUM_W-1:0]             w_sum_add;
    logic [SUM_W+RECIP_W-1:0]     w_prod;
    logic [7:0]                   w_avg;
    logic                         w_hr_valid;

    assign pready     = 1'b1;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_cfg_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep_hours     <= swac_pkg::SLEEP_HOURS_RST;
            r_wake_limit      <= swac_pkg::WAKE_LIMIT_RST;
            r_still_needed    <= swac_pkg::STILL_NEEDED_RST;
            r_low_needed      <= swac_pkg::LOW_PULSE_NEEDED_RST;
            r_sleep_pulse_max <= swac_pkg::SLEEP_PULSE_MAX_RST;
            r_valid_min       <= swac_pkg::VALID_PULSE_MIN_RST;
            r_valid_max       <= swac_pkg::VALID_PULSE_MAX_RST;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                swac_pkg::REG_SLEEP_HOURS:        r_sleep_hours     <= pwdata[4:0];
                swac_pkg::REG_WAKE_LIMIT_SECONDS: r_wake_limit      <= pwdata[16:0];
                swac_pkg::REG_STILL_NEEDED:       r_still_needed    <= pwdata[7:0];
                swac_pkg::REG_LOW_PULSE_NEEDED:   r_low_needed      <= pwdata[7:0];
                swac_pkg::REG_SLEEP_PULSE_MAX:    r_sleep_pulse_max <= pwdata[7:0];
                swac_pkg::REG_VALID_PULSE_MIN:    r_valid_min       <= pwdata[7:0];
                swac_pkg::REG_VALID_PULSE_MAX:    r_valid_max       <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            swac_pkg::REG_SLEEP_HOURS:        prdata = 32'(r_sleep_hours);
            swac_pkg::REG_WAKE_LIMIT_SECONDS: prdata = 32'(r_wake_limit);
            swac_pkg::REG_STILL_NEEDED:       prdata = 32'(r_still_needed);
            swac_pkg::REG_LOW_PULSE_NEEDED:   prdata = 32'(r_low_needed);
            swac_pkg::REG_SLEEP_PULSE_MAX:    prdata = 32'(r_sleep_pulse_max);
            swac_pkg::REG_VALID_PULSE_MIN:    prdata = 32'(r_valid_min);
            swac_pkg::REG_VALID_PULSE_MAX:    prdata = 32'(r_valid_max);
            default:                          prdata = '0;
        endcase
    end

    // countdown load value, clamped by the wake limit
    always_comb begin
        w_full_time = 17'(r_sleep_hours) * 17'(swac_pkg::SECONDS_PER_HOUR);
        if ((r_wake_limit != '0) && (r_wake_limit < w_full_time)) begin
            w_load_time = r_wake_limit;
        end else begin
            w_load_time = w_full_time;
        end
    end

    // window average by reciprocal multiply
    assign w_hr_valid = (i_heart_rate > r_valid_min) && (i_heart_rate < r_valid_max);
    assign w_sum_add  = r_pulse_sum + SUM_W'(i_heart_rate);
    assign w_prod     = (SUM_W+RECIP_W)'(w_sum_add) * (SUM_W+RECIP_W)'(RECIP);
    assign w_avg      = w_prod[RECIP_SHIFT +: 8];

    always_comb begin
        n_mode        = r_mode;
        n_still_secs  = r_still_secs;
        n_low_secs    = r_low_secs;
        n_countdown   = r_countdown;
        n_loaded      = r_loaded;
        n_pulse_sum   = r_pulse_sum;
        n_readings    = r_readings;
        n_res_wake_on = 1'b0;
        n_res_stop    = 1'b0;
        n_res_alert   = 1'b0;
        n_res_rvalid  = 1'b0;
        n_res_avg     = '0;
        if (i_operation == swac_pkg::OP_EVALUATE) begin
            unique case (r_mode)
                swac_pkg::MODE_AWAKE: begin
                    if ((r_still_secs >= r_still_needed) && (r_low_secs >= r_low_needed)) begin
                        n_still_secs = '0;
                        n_low_secs   = '0;
                        n_mode       = swac_pkg::MODE_ASLEEP;
                    end
                end
                swac_pkg::MODE_ASLEEP: begin
                    if (!r_loaded) begin
                        n_countdown = w_load_time;
                        n_loaded    = 1'b1;
                    end
                end
                swac_pkg::MODE_WAKE: begin
                    n_res_wake_on = 1'b1;
                    if (i_button_pressed) begin
                        n_res_stop   = 1'b1;
                        n_mode       = swac_pkg::MODE_AWAKE;
                        n_still_secs = '0;
                        n_low_secs   = '0;
                        n_countdown  = '0;
                        n_loaded     = 1'b0;
                        n_pulse_sum  = '0;
                        n_readings   = '0;
                    end
                end
                default: begin
                end
            endcase
            n_res_alert = (n_mode != swac_pkg::MODE_AWAKE) && i_fall_flagged && i_link_ready;
        end else begin
            unique case (r_mode)
                swac_pkg::MODE_AWAKE: begin
                    if (i_motion_still) begin
                        if (r_still_secs < swac_pkg::COUNT_MAX) begin
                            n_still_secs = r_still_secs + 8'd1;
                        end
                    end else begin
                        n_still_secs = '0;
                    end
                    if ((i_heart_rate >= swac_pkg::PULSE_FLOOR) &&
                        (i_heart_rate <= r_sleep_pulse_max)) begin
                        if (r_low_secs < swac_pkg::COUNT_MAX) begin
                            n_low_secs = r_low_secs + 8'd1;
                        end
                    end else begin
                        n_low_secs = '0;
                    end
                end
                swac_pkg::MODE_ASLEEP: begin
                    if (r_loaded) begin
                        if (r_countdown == '0) begin
                            n_mode = swac_pkg::MODE_WAKE;
                        end else begin
                            n_countdown = r_countdown - 17'd1;
                            if (w_hr_valid) begin
                                if (r_readings == LAST_READING) begin
                                    if ((w_avg >= swac_pkg::PULSE_FLOOR) &&
                                        (w_avg <= swac_pkg::REPORT_MAX)) begin
                                        n_res_rvalid = 1'b1;
                                        n_res_avg    = w_avg;
                                    end
                                    n_pulse_sum = '0;
                                    n_readings  = '0;
                                end else begin
                                    n_pulse_sum = w_sum_add;
                                    n_readings  = r_readings + CNT_W'(1);
                                end
                            end
                        end
                    end
                end
                swac_pkg::MODE_WAKE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= swac_pkg::MODE_AWAKE;
            r_still_secs <= '0;
            r_low_secs   <= '0;
            r_countdown  <= '0;
            r_loaded     <= 1'b0;
            r_pulse_sum  <= '0;
            r_readings   <= '0;
        end else if (w_accept) begin
            r_mode       <= n_mode;
            r_still_secs <= n_still_secs;
            r_low_secs   <= n_low_secs;
            r_countdown  <= n_countdown;
            r_loaded     <= n_loaded;
            r_pulse_sum  <= n_pulse_sum;
            r_readings   <= n_readings;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_mode    <= n_mode;
            r_res_wake_on <= n_res_wake_on;
            r_res_stop    <= n_res_stop;
            r_res_alert   <= n_res_alert;
            r_res_rvalid  <= n_res_rvalid;
            r_res_avg     <= n_res_avg;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_mode              = r_res_mode;
    assign o_wake_actuators_on = r_res_wake_on;
    assign o_actuators_stop    = r_res_stop;
    assign o_fall_alert        = r_res_alert;
    assign o_report_valid      = r_res_rvalid;
    assign o_report_pulse_avg  = r_res_avg;

endmodule

`default_nettype wire

/* design/swac_checker.sv */
// port-level checks for the sleep/wake alarm controller and their bind
`timescale 1ns / 1ps
`default_nettype none

module swac_port_checks (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_ready,
    input wire logic       o_out_valid,
    input wire logic [1:0] o_mode,
    input wire logic       o_wake_actuators_on,
    input wire logic       o_actuators_stop,
    input wire logic       o_fall_alert,
    input wire logic       o_report_valid,
    input wire logic [7:0] o_report_pulse_avg
);

    // a stop only comes from a wake-time evaluate and returns to awake
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_actuators_stop) |->
            (o_wake_actuators_on && (o_mode == swac_pkg::MODE_AWAKE)))
        else $error("actuator stop without wake drive or return to awake");

    // reports come while asleep and stay in range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_report_valid) |->
            ((o_mode == swac_pkg::MODE_ASLEEP) &&
             (o_report_pulse_avg >= swac_pkg::PULSE_FLOOR) &&
             (o_report_pulse_avg <= swac_pkg::REPORT_MAX)))
        else $error("report outside asleep mode or out of range");

    // no report, no average
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_report_valid) |-> (o_report_pulse_avg == 8'd0))
        else $error("average shown without report");

    // falls are never alerted while awake
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fall_alert) |-> (o_mode != swac_pkg::MODE_AWAKE))
        else $error("fall alert while awake");

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_mode) && $stable(o_report_pulse_avg)))
        else $error("stalled result changed");

endmodule

bind sleep_wake_alarm_controller_core swac_port_checks u_swac_port_checks (.*);

`default_nettype wire

/* bench/swac_checker.sv */
// request/result checker with its own copy of the sleep/wake controller behavior
`timescale 1ns / 1ps

module swac_checker
    import swac_pkg::*;
#(
    parameter int REPORT_EVERY = REPORT_EVERY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_operation,
    input  logic               i_motion_still,
    input  logic [7:0]         i_heart_rate,
    input  logic               i_button_pressed,
    input  logic               i_fall_flagged,
    input  logic               i_link_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_mode,
    input  logic               i_wake_actuators_on,
    input  logic               i_actuators_stop,
    input  logic               i_fall_alert,
    input  logic               i_report_valid,
    input  logic [7:0]         i_report_pulse_avg,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    typedef struct packed {
        logic       op;
        logic       still;
        logic [7:0] pulse;
        logic       button;
        logic       fall;
        logic       link;
    } t_sensor_req;

    typedef struct packed {
        logic [1:0] mode;
        logic       wake_on;
        logic       stop;
        logic       alert;
        logic       rep_valid;
        logic [7:0] rep_avg;
    } t_status;

    // configuration copy
    logic [HOURS_W-1:0] hours;
    logic [SECS_W-1:0]  limit;
    logic [BYTE_W-1:0]  still_need;
    logic [BYTE_W-1:0]  low_need;
    logic [BYTE_W-1:0]  pulse_max;
    logic [BYTE_W-1:0]  valid_min;
    logic [BYTE_W-1:0]  valid_max;

    // monitor state
    t_mode              night_mode;
    logic [BYTE_W-1:0]  still_secs;
    logic [BYTE_W-1:0]  low_secs;
    logic [SECS_W-1:0]  countdown;
    logic               loaded;
    int unsigned        pulse_acc;
    int unsigned        readings;

    t_status status_q[$];
    int      mismatches = 0;
    int      results_seen = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic void restart_night();
        still_secs = '0;
        low_secs   = '0;
        countdown  = '0;
        loaded     = 1'b0;
        pulse_acc  = 0;
        readings   = 0;
    endfunction

    function automatic t_status step_monitor(input t_sensor_req req);
        t_status     st;
        int unsigned span;
        int unsigned avg;
        st = '0;
        if (req.op == OP_EVALUATE) begin
            case (night_mode)
                MODE_AWAKE: begin
                    if (still_secs >= still_need && low_secs >= low_need) begin
                        still_secs = '0;
                        low_secs   = '0;
                        night_mode = MODE_ASLEEP;
                    end
                end
                MODE_ASLEEP: begin
                    if (!loaded) begin
                        span = int'(hours) * int'(SECONDS_PER_HOUR);
                        if (limit != 0 && limit < span) begin
                            span = limit;
                        end
                        countdown = span[SECS_W-1:0];
                        loaded    = 1'b1;
                    end
                end
                MODE_WAKE: begin
                    st.wake_on = 1'b1;
                    if (req.button) begin
                        st.stop    = 1'b1;
                        night_mode = MODE_AWAKE;
                        restart_night();
                    end
                end
                default: ;
            endcase
            if (night_mode != MODE_AWAKE && req.fall && req.link) begin
                st.alert = 1'b1;
            end
        end else if (night_mode == MODE_AWAKE) begin
            if (req.still) begin
                if (still_secs != COUNT_MAX) still_secs = still_secs + 1'b1;
            end else begin
                still_secs = '0;
            end
            if (req.pulse >= PULSE_FLOOR && req.pulse <= pulse_max) begin
                if (low_secs != COUNT_MAX) low_secs = low_secs + 1'b1;
            end else begin
                low_secs = '0;
            end
        end else if (night_mode == MODE_ASLEEP && loaded) begin
            if (countdown == 0) begin
                night_mode = MODE_WAKE;
            end else begin
                countdown = countdown - 1'b1;
                if (req.pulse > valid_min && req.pulse < valid_max) begin
                    pulse_acc = pulse_acc + req.pulse;
                    readings  = readings + 1;
                    if (readings >= REPORT_EVERY) begin
                        avg = pulse_acc / REPORT_EVERY;
                        if (avg >= PULSE_FLOOR && avg <= REPORT_MAX) begin
                            st.rep_valid = 1'b1;
                            st.rep_avg   = avg[7:0];
                        end
                        pulse_acc = 0;
                        readings  = 0;
                    end
                end
            end
        end
        st.mode = night_mode;
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_status want;
        if (!i_rst_n) begin
            hours      = SLEEP_HOURS_RST;
            limit      = WAKE_LIMIT_RST;
            still_need = STILL_NEEDED_RST;
            low_need   = LOW_PULSE_NEEDED_RST;
            pulse_max  = SLEEP_PULSE_MAX_RST;
            valid_min  = VALID_PULSE_MIN_RST;
            valid_max  = VALID_PULSE_MAX_RST;
            night_mode = MODE_AWAKE;
            restart_night();
            status_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[4:2]))
                    REG_SLEEP_HOURS:        hours      = i_pwdata[HOURS_W-1:0];
                    REG_WAKE_LIMIT_SECONDS: limit      = i_pwdata[SECS_W-1:0];
                    REG_STILL_NEEDED:       still_need = i_pwdata[BYTE_W-1:0];
                    REG_LOW_PULSE_NEEDED:   low_need   = i_pwdata[BYTE_W-1:0];
                    REG_SLEEP_PULSE_MAX:    pulse_max  = i_pwdata[BYTE_W-1:0];
                    REG_VALID_PULSE_MIN:    valid_min  = i_pwdata[BYTE_W-1:0];
                    REG_VALID_PULSE_MAX:    valid_max  = i_pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = status_q.pop_front();
                    check_field("mode", i_mode, want.mode);
                    check_field("wake_actuators_on", i_wake_actuators_on, want.wake_on);
                    check_field("actuators_stop", i_actuators_stop, want.stop);
                    check_field("fall_alert", i_fall_alert, want.alert);
                    check_field("report_valid", i_report_valid, want.rep_valid);
                    check_field("report_pulse_avg", i_report_pulse_avg, want.rep_avg);
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                status_q.push_back(step_monitor({i_operation, i_motion_still, i_heart_rate,
                                                 i_button_pressed, i_fall_flagged,
                                                 i_link_ready}));
            end
        end
        o_outstanding <= status_q.size();
        o_mismatches  <= mismatches;
    end

endmodule

/* bench/tb_sleep_wake_alarm_controller_core.sv */
// stimulus, handshake pacing and verdict for the sleep/wake alarm controller
`timescale 1ns / 1ps

module tb_sleep_wake_alarm_controller_core;
    import swac_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_REQUESTS = 50;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic [PADDR_W-1:0] paddr            = '0;
    logic [PDATA_W-1:0] pwdata           = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid       = 1'b0;
    logic               o_in_ready;
    logic               i_operation      = OP_EVALUATE;
    logic               i_motion_still   = 1'b0;
    logic [7:0]         i_heart_rate     = '0;
    logic               i_button_pressed = 1'b0;
    logic               i_fall_flagged   = 1'b0;
    logic               i_link_ready     = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready      = 1'b0;
    logic [1:0]         o_mode;
    logic               o_wake_actuators_on;
    logic               o_actuators_stop;
    logic               o_fall_alert;
    logic               o_report_valid;
    logic [7:0]         o_report_pulse_avg;

    int mismatches;
    int outstanding;

    logic [HOURS_W-1:0] cfg_hours;
    logic [SECS_W-1:0]  cfg_limit;
    logic [BYTE_W-1:0]  cfg_still_need;
    logic [BYTE_W-1:0]  cfg_low_need;
    logic [BYTE_W-1:0]  cfg_pulse_max;
    logic [BYTE_W-1:0]  cfg_valid_min;
    logic [BYTE_W-1:0]  cfg_valid_max;

    int requests_sent = 0;
    int burst_left    = 0;
    int holds_asked   = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int stall_style   = 0;
    int style_left    = 0;
    int idle_cycles   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sleep_wake_alarm_controller_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_operation         (i_operation),
        .i_motion_still      (i_motion_still),
        .i_heart_rate        (i_heart_rate),
        .i_button_pressed    (i_button_pressed),
        .i_fall_flagged      (i_fall_flagged),
        .i_link_ready        (i_link_ready),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_mode              (o_mode),
        .o_wake_actuators_on (o_wake_actuators_on),
        .o_actuators_stop    (o_actuators_stop),
        .o_fall_alert        (o_fall_alert),
        .o_report_valid      (o_report_valid),
        .o_report_pulse_avg  (o_report_pulse_avg)
    );

    swac_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_psel              (psel),
        .i_penable           (penable),
        .i_pwrite            (pwrite),
        .i_pready            (pready),
        .i_paddr             (paddr),
        .i_pwdata            (pwdata),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_operation         (i_operation),
        .i_motion_still      (i_motion_still),
        .i_heart_rate        (i_heart_rate),
        .i_button_pressed    (i_button_pressed),
        .i_fall_flagged      (i_fall_flagged),
        .i_link_ready        (i_link_ready),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_mode              (o_mode),
        .i_wake_actuators_on (o_wake_actuators_on),
        .i_actuators_stop    (o_actuators_stop),
        .i_fall_alert        (o_fall_alert),
        .i_report_valid      (o_report_valid),
        .i_report_pulse_avg  (o_report_pulse_avg),
        .o_mismatches        (mismatches),
        .o_outstanding       (outstanding)
    );

    // result side: long hold-offs on demand, otherwise changing stall styles
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(20, 150);
            end
            style_left--;
            case (stall_style)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ((style_left % 7) < 4);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input int value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input int hours, input int limit, input int still_need,
                                input int low_need, input int pulse_max,
                                input int valid_min, input int valid_max);
        write_reg(REG_SLEEP_HOURS, hours);
        write_reg(REG_WAKE_LIMIT_SECONDS, limit);
        write_reg(REG_STILL_NEEDED, still_need);
        write_reg(REG_LOW_PULSE_NEEDED, low_need);
        write_reg(REG_SLEEP_PULSE_MAX, pulse_max);
        write_reg(REG_VALID_PULSE_MIN, valid_min);
        write_reg(REG_VALID_PULSE_MAX, valid_max);
        cfg_hours      = HOURS_W'(hours);
        cfg_limit      = SECS_W'(limit);
        cfg_still_need = BYTE_W'(still_need);
        cfg_low_need   = BYTE_W'(low_need);
        cfg_pulse_max  = BYTE_W'(pulse_max);
        cfg_valid_min  = BYTE_W'(valid_min);
        cfg_valid_max  = BYTE_W'(valid_max);
    endtask

    // wake limits stay short whenever the hour count would give a long countdown
    task automatic apply_random_config();
        int hours;
        int limit;
        int pulse_max;
        int valid_min;
        int valid_max;
        hours     = $urandom_range(0, 31);
        limit     = (hours == 0) ? $urandom_range(0, 131071) : $urandom_range(1, 40);
        pulse_max = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(30, 255);
        valid_min = $urandom_range(0, 150);
        valid_max = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(valid_min, 255);
        apply_config(hours, limit, $urandom_range(0, 16), $urandom_range(0, 16), pulse_max,
                     valid_min, valid_max);
    endtask

    task automatic send_req(input logic op, input logic still, input logic [7:0] pulse,
                            input logic button, input logic fall, input logic link);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_motion_still   <= still;
        i_heart_rate     <= pulse;
        i_button_pressed <= button;
        i_fall_flagged   <= fall;
        i_link_ready     <= link;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        requests_sent++;
    endtask

    task automatic send_tick(input logic still, input logic [7:0] pulse);
        send_req(OP_TICK, still, pulse, 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_eval(input logic button);
        send_req(OP_EVALUATE, 1'($urandom), 8'($urandom), button, 1'($urandom), 1'($urandom));
    endtask

    task automatic send_noise();
        send_req(1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                 1'($urandom));
    endtask

    // wait for every outstanding result, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] low_pulse();
        if (cfg_pulse_max < PULSE_FLOOR) return 8'($urandom);
        return 8'($urandom_range(PULSE_FLOOR, cfg_pulse_max));
    endfunction

    function automatic logic [7:0] valid_pulse();
        if (int'(cfg_valid_max) - int'(cfg_valid_min) < 2) return 8'($urandom);
        return 8'($urandom_range(int'(cfg_valid_min) + 1, int'(cfg_valid_max) - 1));
    endfunction

    function automatic int night_seconds();
        int span;
        span = int'(cfg_hours) * int'(SECONDS_PER_HOUR);
        if (cfg_limit != 0 && cfg_limit < span) span = cfg_limit;
        return span;
    endfunction

    // try to fall asleep, sleep through the countdown, wake and press the button
    task automatic run_night(input bit force_clean);
        int  need;
        int  awake_ticks;
        bit  clean;
        need        = (cfg_still_need > cfg_low_need) ? cfg_still_need : cfg_low_need;
        clean       = force_clean || ($urandom_range(0, 4) != 0);
        awake_ticks = need + $urandom_range(0, 4);
        if (!clean) awake_ticks = $urandom_range(0, awake_ticks);
        repeat (awake_ticks) begin
            if (clean) begin
                send_tick(1'b1, low_pulse());
            end else if ($urandom_range(0, 5) == 0) begin
                send_eval(1'($urandom));
            end else begin
                send_tick(1'($urandom_range(0, 5) != 0),
                          ($urandom_range(0, 2) != 0) ? low_pulse() : 8'($urandom));
            end
        end
        send_eval(1'($urandom_range(0, 5) == 0));
        send_eval(1'($urandom_range(0, 5) == 0));
        repeat (night_seconds() + 1) begin
            if ($urandom_range(0, 9) == 0) begin
                send_eval(1'($urandom));
            end else begin
                send_tick(1'($urandom), ($urandom_range(0, 4) != 0) ? valid_pulse() : 8'($urandom));
            end
        end
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1) == 0) begin
                send_tick(1'($urandom), 8'($urandom));
            end else begin
                send_eval(1'b0);
            end
        end
        send_eval(1'b1);
    endtask

    task automatic run_phase(input int budget);
        int start;
        start = requests_sent;
        while (requests_sent - start < budget) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 6)) send_noise();
            end
            run_night(1'b0);
        end
        drain();
    endtask

    task automatic run_directed();
        // counting, count resets, early fall, tick before load, zero countdown, wake
        apply_config(0, 0, 2, 1, 30, 0, 255);
        send_req(OP_EVALUATE, 1'b1, 8'd0,   1'b1, 1'b1, 1'b1);
        send_req(OP_TICK,     1'b1, 8'd29,  1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b1, 8'd30,  1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd255, 1'b1, 1'b1, 1'b1);
        send_req(OP_TICK,     1'b1, 8'd30,  1'b0, 1'b1, 1'b1);
        send_req(OP_TICK,     1'b1, 8'd30,  1'b0, 1'b0, 1'b0);
        send_req(OP_EVALUATE, 1'b0, 8'd0,   1'b0, 1'b1, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd100, 1'b0, 1'b0, 1'b0);
        send_req(OP_EVALUATE, 1'b0, 8'd0,   1'b0, 1'b1, 1'b1);
        send_req(OP_EVALUATE, 1'b0, 8'd0,   1'b1, 1'b0, 1'b1);
        send_req(OP_TICK,     1'b0, 8'd100, 1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd100, 1'b1, 1'b0, 1'b0);
        send_req(OP_EVALUATE, 1'b0, 8'd0,   1'b0, 1'b1, 1'b1);
        send_req(OP_EVALUATE, 1'b1, 8'd255, 1'b1, 1'b1, 1'b1);
        drain();
        // zero thresholds, clamped countdown, reading bounds and report range
        apply_config(24, 8, 0, 0, 255, 0, 255);
        send_req(OP_EVALUATE, 1'b0, 8'd0,   1'b0, 1'b0, 1'b0);
        send_req(OP_EVALUATE, 1'b0, 8'd0,   1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd0,   1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd255, 1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd1,   1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd58,  1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd200, 1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd201, 1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd202, 1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd201, 1'b0, 1'b0, 1'b0);
        send_req(OP_TICK,     1'b0, 8'd90,  1'b0, 1'b0, 1'b0);
        send_req(OP_EVALUATE, 1'b0, 8'd0,   1'b1, 1'b1, 1'b1);
        drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        // saturating counts with the longest thresholds
        apply_config(24, 40, 255, 255, 255, 0, 255);
        holds_asked++;
        run_night(1'b1);
        run_night(1'b1);
        drain();
        // widest wake limit, no valid reading possible
        apply_config(0, 131071, 1, 1, 30, 255, 0);
        run_phase(60);
        for (int phase = 0; phase < 8; phase++) begin
            apply_random_config();
            if (phase == 0 || phase == 4) holds_asked++;
            run_phase(PHASE_REQUESTS);
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
